[design/i2cbm_pkg.sv]
// Shared types and constants for the I2C byte master.
// Holds the transaction payload structs, state record, phase codes and register map.
// No dependencies.
package i2cbm_pkg;

  localparam int unsigned PhaseW = 5;
  localparam int unsigned AddrW  = 4;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_TX    = 3'd2;
  localparam logic [2:0] FUNC_AWAIT = 3'd3;
  localparam logic [2:0] FUNC_RX    = 3'd4;
  localparam logic [2:0] FUNC_STOP  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOACK  = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;
  localparam logic [1:0] ST_HELD   = 2'd3;

  localparam logic [1:0] REG_ACK_RETRY     = 2'd0;
  localparam logic [1:0] REG_STRETCH_RETRY = 2'd1;
  localparam logic [1:0] REG_IDLE_RETRY    = 2'd2;
  localparam logic [1:0] REG_STOP_EXTRA    = 2'd3;

  localparam logic [7:0]  ACK_RETRY_RST     = 8'd50;
  localparam logic [7:0]  STRETCH_RETRY_RST = 8'd10;
  localparam logic [15:0] IDLE_RETRY_RST    = 16'd5000;
  localparam logic [7:0]  STOP_EXTRA_RST    = 8'd27;

  localparam logic [PhaseW-1:0] PH_IDLE    = 5'd0;
  localparam logic [PhaseW-1:0] PH_S_REL   = 5'd1;
  localparam logic [PhaseW-1:0] PH_S_WAIT  = 5'd2;
  localparam logic [PhaseW-1:0] PH_S_SCL   = 5'd3;
  localparam logic [PhaseW-1:0] PH_T_LSDA  = 5'd4;
  localparam logic [PhaseW-1:0] PH_T_LSCL  = 5'd5;
  localparam logic [PhaseW-1:0] PH_T_BSDA  = 5'd6;
  localparam logic [PhaseW-1:0] PH_T_BSCLH = 5'd7;
  localparam logic [PhaseW-1:0] PH_T_BSCLL = 5'd8;
  localparam logic [PhaseW-1:0] PH_T_ADLY  = 5'd9;
  localparam logic [PhaseW-1:0] PH_T_ASCLH = 5'd10;
  localparam logic [PhaseW-1:0] PH_T_ASDAH = 5'd11;
  localparam logic [PhaseW-1:0] PH_T_APOLL = 5'd12;
  localparam logic [PhaseW-1:0] PH_A_SDA   = 5'd13;
  localparam logic [PhaseW-1:0] PH_A_SCL   = 5'd14;
  localparam logic [PhaseW-1:0] PH_R_SCLL  = 5'd15;
  localparam logic [PhaseW-1:0] PH_R_SDAH  = 5'd16;
  localparam logic [PhaseW-1:0] PH_R_SCLH  = 5'd17;
  localparam logic [PhaseW-1:0] PH_R_SAMP  = 5'd18;
  localparam logic [PhaseW-1:0] PH_R_ASDA  = 5'd19;
  localparam logic [PhaseW-1:0] PH_R_ASCL  = 5'd20;
  localparam logic [PhaseW-1:0] PH_R_DLY   = 5'd21;
  localparam logic [PhaseW-1:0] PH_P_SDA   = 5'd22;
  localparam logic [PhaseW-1:0] PH_P_SCL   = 5'd23;
  localparam logic [PhaseW-1:0] PH_P_DLY   = 5'd24;
  localparam logic [PhaseW-1:0] PH_P_WAIT  = 5'd25;
  localparam logic [PhaseW-1:0] PH_P_SCLH  = 5'd26;
  localparam logic [PhaseW-1:0] PH_P_SDAH  = 5'd27;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       lead_low;
    logic       stop_extra_wait;
    logic       scl_in;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [7:0]  ack_retry_limit;
    logic [7:0]  stretch_retry_limit;
    logic [15:0] idle_retry_limit;
    logic [7:0]  stop_extra_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [3:0]        bit_count;
    logic [7:0]        shift_reg;
    logic [15:0]       wait_count;
    logic              scl_drive;
    logic              sda_drive;
    logic [1:0]        last_status;
    logic [7:0]        rx_hold;
  } state_t;

endpackage

[design/i2cbm_step.sv]
// One symbol-time step of the I2C byte master sequencer.
// Combinational next state and result from current state, input item and registers.
// Depends on i2cbm_pkg.
module i2cbm_step (
  input  i2cbm_pkg::state_t cur_i,
  input  i2cbm_pkg::in_t    item_i,
  input  i2cbm_pkg::cfg_t   cfg_i,
  output i2cbm_pkg::state_t nxt_o,
  output i2cbm_pkg::out_t   res_o
);
  import i2cbm_pkg::*;

  state_t     st;
  logic       done;
  logic [15:0] wc_inc;

  always_comb begin
    st     = cur_i;
    done   = 1'b0;
    wc_inc = 16'd0;

    if (st.phase == PH_IDLE && item_i.func >= FUNC_START && item_i.func <= FUNC_STOP) begin
      st.last_status = ST_OK;
      st.wait_count  = 16'd0;
      st.bit_count   = 4'd0;
      if (item_i.func == FUNC_START) begin
        st.phase = PH_S_REL;
      end else if (item_i.func == FUNC_TX) begin
        st.shift_reg = item_i.tx_byte;
        st.phase     = item_i.lead_low ? PH_T_LSDA : PH_T_BSDA;
      end else if (item_i.func == FUNC_AWAIT) begin
        st.phase = PH_A_SDA;
      end else if (item_i.func == FUNC_RX) begin
        st.phase = PH_R_SCLL;
      end else begin
        st.wait_count = item_i.stop_extra_wait ? {8'd0, cfg_i.stop_extra_ticks} : 16'd0;
        st.phase      = PH_P_SDA;
      end
    end

    wc_inc = st.wait_count + 16'd1;

    if (st.phase != PH_IDLE) begin
      unique case (st.phase)
        PH_S_REL: begin
          st.scl_drive  = 1'b0;
          st.sda_drive  = 1'b0;
          st.wait_count = 16'd0;
          st.phase      = PH_S_WAIT;
        end
        PH_S_WAIT: begin
          if (item_i.scl_in && item_i.sda_in) begin
            st.sda_drive = 1'b1;
            st.phase     = PH_S_SCL;
          end else begin
            st.wait_count = wc_inc;
            if (wc_inc >= cfg_i.idle_retry_limit) begin
              st.last_status = ST_LOCKED;
              st.sda_drive   = 1'b1;
              st.phase       = PH_S_SCL;
            end
          end
        end
        PH_S_SCL: begin
          st.scl_drive = 1'b1;
          done         = 1'b1;
        end
        PH_T_LSDA: begin
          st.sda_drive = 1'b1;
          st.phase     = PH_T_LSCL;
        end
        PH_T_LSCL: begin
          st.scl_drive = 1'b1;
          st.phase     = PH_T_BSDA;
        end
        PH_T_BSDA: begin
          st.sda_drive = ~st.shift_reg[3'd7 - st.bit_count[2:0]];
          st.phase     = PH_T_BSCLH;
        end
        PH_T_BSCLH: begin
          st.scl_drive = 1'b0;
          st.phase     = PH_T_BSCLL;
        end
        PH_T_BSCLL: begin
          st.scl_drive = 1'b1;
          st.bit_count = st.bit_count + 4'd1;
          st.phase     = (st.bit_count >= 4'd8) ? PH_T_ADLY : PH_T_BSDA;
        end
        PH_T_ADLY: begin
          st.phase = PH_T_ASCLH;
        end
        PH_T_ASCLH: begin
          st.scl_drive = 1'b0;
          st.phase     = PH_T_ASDAH;
        end
        PH_T_ASDAH: begin
          st.sda_drive  = 1'b0;
          st.wait_count = 16'd0;
          st.phase      = PH_T_APOLL;
        end
        PH_T_APOLL: begin
          if (!item_i.sda_in) begin
            done = 1'b1;
          end else begin
            st.wait_count = wc_inc;
            if (wc_inc >= {8'd0, cfg_i.ack_retry_limit}) begin
              st.last_status = ST_NOACK;
              done           = 1'b1;
            end
          end
        end
        PH_A_SDA: begin
          if (!item_i.sda_in) begin
            st.wait_count = 16'd0;
            st.phase      = PH_A_SCL;
          end else begin
            st.wait_count = wc_inc;
            if (wc_inc >= {8'd0, cfg_i.ack_retry_limit}) begin
              st.last_status = ST_NOACK;
              done           = 1'b1;
            end
          end
        end
        PH_A_SCL: begin
          if (item_i.scl_in) begin
            done = 1'b1;
          end else begin
            st.wait_count = wc_inc;
            if (wc_inc >= {8'd0, cfg_i.stretch_retry_limit}) begin
              st.last_status = ST_HELD;
              done           = 1'b1;
            end
          end
        end
        PH_R_SCLL: begin
          st.scl_drive = 1'b1;
          st.phase     = PH_R_SDAH;
        end
        PH_R_SDAH: begin
          st.sda_drive = 1'b0;
          st.shift_reg = 8'd0;
          st.bit_count = 4'd0;
          st.phase     = PH_R_SCLH;
        end
        PH_R_SCLH: begin
          st.scl_drive = 1'b0;
          st.phase     = PH_R_SAMP;
        end
        PH_R_SAMP: begin
          st.shift_reg = {st.shift_reg[6:0], item_i.sda_in};
          st.scl_drive = 1'b1;
          st.bit_count = st.bit_count + 4'd1;
          if (st.bit_count >= 4'd8) begin
            st.rx_hold = st.shift_reg;
            st.phase   = PH_R_ASDA;
          end else begin
            st.phase = PH_R_SCLH;
          end
        end
        PH_R_ASDA: begin
          st.sda_drive = 1'b1;
          st.phase     = PH_R_ASCL;
        end
        PH_R_ASCL: begin
          st.scl_drive = 1'b0;
          st.phase     = PH_R_DLY;
        end
        PH_R_DLY: begin
          done = 1'b1;
        end
        PH_P_SDA: begin
          st.sda_drive = 1'b1;
          st.phase     = PH_P_SCL;
        end
        PH_P_SCL: begin
          st.scl_drive = 1'b1;
          st.phase     = PH_P_DLY;
        end
        PH_P_DLY: begin
          st.phase = (st.wait_count != 16'd0) ? PH_P_WAIT : PH_P_SCLH;
        end
        PH_P_WAIT: begin
          if (st.wait_count != 16'd0) begin
            st.wait_count = st.wait_count - 16'd1;
          end
          if (st.wait_count == 16'd0) begin
            st.phase = PH_P_SCLH;
          end
        end
        PH_P_SCLH: begin
          st.scl_drive = 1'b0;
          st.phase     = PH_P_SDAH;
        end
        PH_P_SDAH: begin
          st.sda_drive = 1'b0;
          done         = 1'b1;
        end
        default: begin
          st.phase = PH_IDLE;
        end
      endcase
      if (done) begin
        st.phase = PH_IDLE;
      end
    end
  end

  assign nxt_o          = st;
  assign res_o.scl_low  = st.scl_drive;
  assign res_o.sda_low  = st.sda_drive;
  assign res_o.busy_res = (st.phase != PH_IDLE);
  assign res_o.done_res = done;
  assign res_o.rx_byte  = st.rx_hold;
  assign res_o.status   = st.last_status;

endmodule

[design/i2c_byte_master.sv]
// Top level of the I2C byte master: state register, register file and result buffering.
// Instantiates i2cbm_step; depends on i2cbm_pkg.
//
// Usage:
//   in_*  : one transaction per symbol-time tick (func, tx_byte, lead_low,
//           stop_extra_wait, sampled scl_in / sda_in). Accepted when in_valid
//           is high and in_stall is low.
//   out_* : one result transaction per accepted tick (line drives, busy, done,
//           rx_byte, status), in order.
//   APB   : four registers at byte addresses 0x0, 0x4, 0x8, 0xC (ack retry,
//           stretch retry, idle retry, stop extra ticks). Write only while idle.
// Each accepted result is registered in the output or skid register; one tick
// is accepted every cycle while in_stall is low. The step logic is a single
// pass over the sequencer state, registered once per tick.
// A two-entry result buffer (output register plus skid register) accepts
// one more input tick after out_stall rises; in_stall follows the skid entry.
// Reset: synchronous, active low; sequencer idle, lines released, status ok,
// registers at their defaults, no result pending.
module i2c_byte_master (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  i2cbm_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output i2cbm_pkg::out_t             out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cbm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import i2cbm_pkg::*;

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  out_t   res;
  out_t   out_data_r;
  out_t   skid_data_r;
  logic   out_valid_r;
  logic   skid_valid_r;
  logic   accept;
  logic   out_take;
  logic   cfg_wr;
  logic [1:0] reg_idx;

  assign reg_idx  = paddr[3:2];
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_retry_limit     <= ACK_RETRY_RST;
      cfg_r.stretch_retry_limit <= STRETCH_RETRY_RST;
      cfg_r.idle_retry_limit    <= IDLE_RETRY_RST;
      cfg_r.stop_extra_ticks    <= STOP_EXTRA_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACK_RETRY:     cfg_r.ack_retry_limit     <= pwdata[7:0];
        REG_STRETCH_RETRY: cfg_r.stretch_retry_limit <= pwdata[7:0];
        REG_IDLE_RETRY:    cfg_r.idle_retry_limit    <= pwdata[15:0];
        REG_STOP_EXTRA:    cfg_r.stop_extra_ticks    <= pwdata[7:0];
        default:           cfg_r                     <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACK_RETRY:     prdata = {24'd0, cfg_r.ack_retry_limit};
      REG_STRETCH_RETRY: prdata = {24'd0, cfg_r.stretch_retry_limit};
      REG_IDLE_RETRY:    prdata = {16'd0, cfg_r.idle_retry_limit};
      REG_STOP_EXTRA:    prdata = {24'd0, cfg_r.stop_extra_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  i2cbm_step u_step (
    .cur_i  (state_r),
    .item_i (in_data),
    .cfg_i  (cfg_r),
    .nxt_o  (state_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_stalled_accept_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("transaction accepted under stall was not buffered");

  a_state_holds_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(state_r))
    else $error("sequencer state moved without a transaction");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("result flags done and busy together");

endmodule
